// ===== rtl/core/eum_pkg.sv =====
// Package with the shared types, codes and symbol tables of the EAN/UPC module encoder.
`timescale 1ns / 1ps

package eum_pkg;

	// Number of character lanes, one for each supplied character position.
	localparam int NUM_LANES = 13;

	// Symbologies selected by the mode field.
	typedef enum logic [1:0] {
		MODE_EAN13 = 2'd0,
		MODE_UPCA  = 2'd1,
		MODE_EAN8  = 2'd2,
		MODE_UPCE  = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEN   = 3'd1,
		ST_BAD_DIGIT = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_BAD_NS    = 3'd4
	} status_t;

	// Module counts of the three symbol sizes.
	localparam logic [6:0] MC_FULL = 7'd95;
	localparam logic [6:0] MC_EAN8 = 7'd67;
	localparam logic [6:0] MC_UPCE = 7'd51;

	// Guard patterns, first module in the highest bit.
	localparam logic [2:0] GUARD_SIDE   = 3'b101;
	localparam logic [4:0] GUARD_CENTER = 5'b01010;
	localparam logic [5:0] GUARD_UPCE   = 6'b010101;

	// What one character lane reports about its character.
	typedef struct packed {
		logic       bad;     // non-decimal character inside the supplied count
		logic [5:0] wterm;   // weighted term of the check digit sum
		logic [6:0] code_l;  // odd parity left code
		logic [6:0] code_g;  // even parity left code
		logic [6:0] code_r;  // right code
	} lane_t;

	// Stage enables handed from the pipeline control to the merging stage.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} pipe_ctl_t;

	// Left hand odd parity codes.
	function automatic logic [6:0] code_l_of(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'd0: c = 7'h0D;
			4'd1: c = 7'h19;
			4'd2: c = 7'h13;
			4'd3: c = 7'h3D;
			4'd4: c = 7'h23;
			4'd5: c = 7'h31;
			4'd6: c = 7'h2F;
			4'd7: c = 7'h3B;
			4'd8: c = 7'h37;
			4'd9: c = 7'h0B;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Left hand even parity codes.
	function automatic logic [6:0] code_g_of(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'd0: c = 7'h27;
			4'd1: c = 7'h33;
			4'd2: c = 7'h1B;
			4'd3: c = 7'h21;
			4'd4: c = 7'h1D;
			4'd5: c = 7'h39;
			4'd6: c = 7'h05;
			4'd7: c = 7'h11;
			4'd8: c = 7'h09;
			4'd9: c = 7'h17;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Right hand codes.
	function automatic logic [6:0] code_r_of(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'd0: c = 7'h72;
			4'd1: c = 7'h66;
			4'd2: c = 7'h6C;
			4'd3: c = 7'h42;
			4'd4: c = 7'h5C;
			4'd5: c = 7'h4E;
			4'd6: c = 7'h50;
			4'd7: c = 7'h44;
			4'd8: c = 7'h48;
			4'd9: c = 7'h74;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// EAN-13 parity masks from the leading digit; first left digit at bit 5, 1 = even.
	function automatic logic [5:0] par_ean13_of(input logic [3:0] d);
		logic [5:0] p;
		unique case (d)
			4'd0: p = 6'h00;
			4'd1: p = 6'h0B;
			4'd2: p = 6'h0D;
			4'd3: p = 6'h0E;
			4'd4: p = 6'h13;
			4'd5: p = 6'h19;
			4'd6: p = 6'h1C;
			4'd7: p = 6'h15;
			4'd8: p = 6'h16;
			4'd9: p = 6'h1A;
			default: p = 6'h00;
		endcase
		return p;
	endfunction

	// UPC-E parity masks for number system 0, chosen by the check digit.
	function automatic logic [5:0] par_upce0_of(input logic [3:0] d);
		logic [5:0] p;
		unique case (d)
			4'd0: p = 6'h38;
			4'd1: p = 6'h34;
			4'd2: p = 6'h32;
			4'd3: p = 6'h31;
			4'd4: p = 6'h2C;
			4'd5: p = 6'h26;
			4'd6: p = 6'h23;
			4'd7: p = 6'h2A;
			4'd8: p = 6'h29;
			4'd9: p = 6'h25;
			default: p = 6'h00;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/ean_upc_module_encoder.sv =====
// Top level of the EAN-13 / UPC-A / EAN-8 / UPC-E module encoder with its stream ports.
//
//  channel  direction  payload (lowest bits first)
//  s_axis   in         mode[1:0], digit_count[5:2], digits[57:6], zero fill to 64
//  m_axis   out        status[2:0], check_digit[6:3], module_count[13:7],
//                      modules_first[61:14], modules_rest[108:62], zero fill to 112
//
// Each item passes three register stages: the character lanes, the lane sum, and the
// check digit and module layout in the output register, from which the result is
// offered. One
// item is taken every cycle; each stage holds only while the stage after it is full
// and stalled, so s_axis_tready falls only when all three stages are full and
// m_axis_tready is low. Reset clears the stage valid bits.
`timescale 1ns / 1ps

module ean_upc_module_encoder import eum_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // mode, digit_count, digits
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata    // status, check_digit, module_count, modules_first, modules_rest
);

	// Input fields.
	mode_t       mode;
	logic [3:0]  digit_count;
	logic [51:0] digits;

	// Stage control.
	logic        v_s1_q;
	logic        v_s2_q;
	logic        v_s3_q;
	logic        en_s1;
	pipe_ctl_t   ctl;

	// Lane outputs and stage 1 registers.
	lane_t       lanes [NUM_LANES];
	lane_t       lanes_s1 [NUM_LANES];
	mode_t       mode_s1;
	logic        len_ok_s1;
	logic        given_s1;
	logic [51:0] digits_s1;
	logic        len_ok;
	logic        given;

	// Output stage payload.
	status_t     status_s3;
	logic [3:0]  check_digit_s3;
	logic [6:0]  module_count_s3;
	logic [47:0] modules_first_s3;
	logic [46:0] modules_rest_s3;

	assign mode        = mode_t'(s_axis_tdata[1:0]);
	assign digit_count = s_axis_tdata[5:2];
	assign digits      = s_axis_tdata[57:6];

	// A stage advances when it is empty or the stage after it advances.
	assign ctl.en_s3     = !v_s3_q || m_axis_tready;
	assign ctl.en_s2     = !v_s2_q || ctl.en_s3;
	assign en_s1         = !v_s1_q || ctl.en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1_q <= s_axis_tvalid;
			end
			if (ctl.en_s2) begin
				v_s2_q <= v_s1_q;
			end
			if (ctl.en_s3) begin
				v_s3_q <= v_s2_q;
			end
		end
	end

	// One lane for each character position.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		eum_lane u_lane (
			.idx         (4'(g)),
			.mode        (mode),
			.digit_count (digit_count),
			.nib         (digits[4*g +: 4]),
			.res         (lanes[g])
		);
	end

	// Length rule and whether the check digit was supplied.
	always_comb begin
		unique case (mode)
			MODE_EAN13: begin
				len_ok = (digit_count == 4'd12) || (digit_count == 4'd13);
				given  = (digit_count == 4'd13);
			end
			MODE_UPCA: begin
				len_ok = (digit_count == 4'd11) || (digit_count == 4'd12);
				given  = (digit_count == 4'd12);
			end
			MODE_EAN8: begin
				len_ok = (digit_count == 4'd7) || (digit_count == 4'd8);
				given  = (digit_count == 4'd8);
			end
			default: begin
				len_ok = (digit_count == 4'd8);
				given  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			lanes_s1  <= lanes;
			mode_s1   <= mode;
			len_ok_s1 <= len_ok;
			given_s1  <= given;
			digits_s1 <= digits;
		end
	end

	eum_merge u_merge (
		.clk              (clk),
		.ctl              (ctl),
		.mode_s1          (mode_s1),
		.len_ok_s1        (len_ok_s1),
		.given_s1         (given_s1),
		.digits_s1        (digits_s1),
		.lanes_s1         (lanes_s1),
		.status_s3        (status_s3),
		.check_digit_s3   (check_digit_s3),
		.module_count_s3  (module_count_s3),
		.modules_first_s3 (modules_first_s3),
		.modules_rest_s3  (modules_rest_s3)
	);

	assign m_axis_tvalid = v_s3_q;
	assign m_axis_tdata  = {3'd0, modules_rest_s3, modules_first_s3, module_count_s3,
		check_digit_s3, status_s3};

	// Input is refused only when every stage holds an item.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1_q && v_s2_q && v_s3_q))
		else $error("input stalled with an empty stage");

	// A good result always carries a symbol size.
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (status_s3 == ST_OK)) |->
		((module_count_s3 == MC_FULL) || (module_count_s3 == MC_EAN8) ||
		(module_count_s3 == MC_UPCE)))
		else $error("good result without a symbol size");

	// An error result carries no modules.
	a_err_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (status_s3 != ST_OK)) |->
		((module_count_s3 == 7'd0) && (modules_first_s3 == '0) && (modules_rest_s3 == '0)))
		else $error("error result with modules");

	// A result that is taken while stage 2 is full is replaced by the next one.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && v_s2_q) |=> m_axis_tvalid)
		else $error("output stage not refilled");

endmodule

// ===== rtl/core/eum_lane.sv =====
// One character lane: validates a character, forms its check sum term and looks up its codes.
`timescale 1ns / 1ps

module eum_lane import eum_pkg::*; (
	input  logic [3:0] idx,
	input  mode_t      mode,
	input  logic [3:0] digit_count,
	input  logic [3:0] nib,
	output lane_t      res
);

	logic       in_sum;
	logic       weight3;
	logic [5:0] triple;

	// A character only counts as bad when it lies inside the supplied count.
	assign res.bad = (nib > 4'd9) && (idx < digit_count);

	// Which positions enter the check sum and which carry weight three.
	always_comb begin
		unique case (mode)
			MODE_EAN13: begin
				in_sum  = (idx < 4'd12);
				weight3 = idx[0];
			end
			MODE_UPCA: begin
				in_sum  = (idx < 4'd11);
				weight3 = ~idx[0];
			end
			MODE_EAN8: begin
				in_sum  = (idx < 4'd7);
				weight3 = ~idx[0];
			end
			default: begin
				in_sum  = 1'b0;
				weight3 = 1'b0;
			end
		endcase
	end

	assign triple    = {1'b0, nib, 1'b0} + {2'b00, nib};
	assign res.wterm = !in_sum ? 6'd0 : (weight3 ? triple : {2'b00, nib});

	// Code lookups for this character.
	assign res.code_l = code_l_of(nib);
	assign res.code_g = code_g_of(nib);
	assign res.code_r = code_r_of(nib);

endmodule

// ===== rtl/core/eum_merge.sv =====
// Merging stages: sums the lane terms, settles the check digit and status, and lays out the modules.
`timescale 1ns / 1ps

module eum_merge import eum_pkg::*; (
	input  logic        clk,
	input  pipe_ctl_t   ctl,
	input  mode_t       mode_s1,
	input  logic        len_ok_s1,
	input  logic        given_s1,
	input  logic [51:0] digits_s1,
	input  lane_t       lanes_s1 [NUM_LANES],
	output status_t     status_s3,
	output logic [3:0]  check_digit_s3,
	output logic [6:0]  module_count_s3,
	output logic [47:0] modules_first_s3,
	output logic [46:0] modules_rest_s3
);

	// Stage 2 registers.
	mode_t       mode_s2;
	status_t     pre_status_s2;
	logic        given_s2;
	logic [51:0] digits_s2;
	logic [8:0]  sum_lo_s2;
	logic [8:0]  sum_hi_s2;
	lane_t       lanes_s2 [NUM_LANES];

	// Stage 2 combinational signals.
	logic        any_bad;
	logic [8:0]  sum_lo;
	logic [8:0]  sum_hi;

	// Stage 3 combinational signals.
	logic [9:0]  sum;
	logic [17:0] prod;
	logic [6:0]  quot;
	logic [3:0]  rem;
	logic [3:0]  cd;
	logic [3:0]  nib0;
	logic [3:0]  nib7;
	logic [3:0]  supplied;
	logic [5:0]  parity;
	logic [41:0] left_full;
	logic [41:0] right_full;
	logic [27:0] left_ean8;
	logic [27:0] right_ean8;
	logic [6:0]  cd_code_r;
	logic [94:0] mods;
	status_t     status_n;
	logic [3:0]  cd_n;
	logic [6:0]  mc_n;

	// Lane findings folded into a status and two partial sums.
	always_comb begin
		any_bad = 1'b0;
		sum_lo  = '0;
		sum_hi  = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			any_bad = any_bad | lanes_s1[i].bad;
		end
		for (int i = 0; i < 7; i++) begin
			sum_lo = sum_lo + 9'(lanes_s1[i].wterm);
		end
		for (int i = 7; i < NUM_LANES; i++) begin
			sum_hi = sum_hi + 9'(lanes_s1[i].wterm);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			mode_s2       <= mode_s1;
			given_s2      <= given_s1;
			digits_s2     <= digits_s1;
			sum_lo_s2     <= sum_lo;
			sum_hi_s2     <= sum_hi;
			lanes_s2      <= lanes_s1;
			pre_status_s2 <= !len_ok_s1 ? ST_BAD_LEN : (any_bad ? ST_BAD_DIGIT : ST_OK);
		end
	end

	// Modulo 10 of the sum by a reciprocal multiply; exact for sums below 1023.
	assign sum  = {1'b0, sum_lo_s2} + {1'b0, sum_hi_s2};
	assign prod = {8'd0, sum} * 18'd205;
	assign quot = prod[17:11];
	assign rem  = 4'(sum - ({3'd0, quot} * 10'd10));
	assign cd   = (rem == 4'd0) ? 4'd0 : 4'(4'd10 - rem);

	assign nib0 = digits_s2[3:0];
	assign nib7 = digits_s2[31:28];
	assign cd_code_r = code_r_of(cd);

	// Supplied check digit and left hand parity per symbology.
	always_comb begin
		unique case (mode_s2)
			MODE_EAN13: begin
				supplied = digits_s2[51:48];
				parity   = par_ean13_of(nib0);
			end
			MODE_UPCA: begin
				supplied = digits_s2[47:44];
				parity   = 6'h00;
			end
			MODE_EAN8: begin
				supplied = digits_s2[31:28];
				parity   = 6'h00;
			end
			default: begin
				supplied = nib7;
				parity   = par_upce0_of(nib7) ^ ((nib0 == 4'd1) ? 6'h3F : 6'h00);
			end
		endcase
	end

	// Left and right halves, one seven module code for each position.
	always_comb begin
		left_full  = '0;
		right_full = '0;
		left_ean8  = '0;
		right_ean8 = '0;
		for (int i = 0; i < 6; i++) begin
			if (mode_s2 == MODE_UPCA) begin
				left_full[41 - 7*i -: 7] = lanes_s2[i].code_l;
			end else if (parity[5 - i]) begin
				left_full[41 - 7*i -: 7] = lanes_s2[i + 1].code_g;
			end else begin
				left_full[41 - 7*i -: 7] = lanes_s2[i + 1].code_l;
			end
		end
		for (int i = 0; i < 5; i++) begin
			if (mode_s2 == MODE_UPCA) begin
				right_full[41 - 7*i -: 7] = lanes_s2[i + 6].code_r;
			end else begin
				right_full[41 - 7*i -: 7] = lanes_s2[i + 7].code_r;
			end
		end
		right_full[6:0] = cd_code_r;
		for (int i = 0; i < 4; i++) begin
			left_ean8[27 - 7*i -: 7] = lanes_s2[i].code_l;
		end
		for (int i = 0; i < 3; i++) begin
			right_ean8[27 - 7*i -: 7] = lanes_s2[i + 4].code_r;
		end
		right_ean8[6:0] = cd_code_r;
	end

	// Final status, check digit and module layout.
	always_comb begin
		status_n = pre_status_s2;
		cd_n     = 4'd0;
		mc_n     = 7'd0;
		mods     = '0;
		if (pre_status_s2 == ST_OK) begin
			unique case (mode_s2) inside
				MODE_EAN13, MODE_UPCA: begin
					cd_n = cd;
					if (given_s2 && (supplied != cd)) begin
						status_n = ST_MISMATCH;
					end else begin
						mc_n = MC_FULL;
						mods = {GUARD_SIDE, left_full, GUARD_CENTER, right_full, GUARD_SIDE};
					end
				end
				MODE_EAN8: begin
					cd_n = cd;
					if (given_s2 && (supplied != cd)) begin
						status_n = ST_MISMATCH;
					end else begin
						mc_n = MC_EAN8;
						mods = {GUARD_SIDE, left_ean8, GUARD_CENTER, right_ean8, GUARD_SIDE,
							28'd0};
					end
				end
				default: begin
					cd_n = nib7;
					if (nib0 > 4'd1) begin
						status_n = ST_BAD_NS;
					end else begin
						mc_n = MC_UPCE;
						mods = {GUARD_SIDE, left_full, GUARD_UPCE, 44'd0};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			status_s3        <= status_n;
			check_digit_s3   <= cd_n;
			module_count_s3  <= mc_n;
			modules_first_s3 <= mods[94:47];
			modules_rest_s3  <= mods[46:0];
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the EAN/UPC module encoder: directed and random requests, checked results.
`timescale 1ns / 1ps

module testbench;
	import eum_pkg::*;

	// One request as it travels in s_axis_tdata, mode in the lowest bits.
	typedef struct packed {
		logic [51:0] digits;
		logic [3:0]  count;
		mode_t       mode;
	} request_t;

	// One result as it travels in m_axis_tdata, status in the lowest bits.
	typedef struct packed {
		logic [46:0] rest;
		logic [47:0] first;
		logic [6:0]  mod_count;
		logic [3:0]  check;
		status_t     status;
	} symbol_t;

	// Character code tables, digit 0 in the lowest slice.
	localparam logic [69:0] CODES_L = {7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31,
		7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
	localparam logic [69:0] CODES_G = {7'h17, 7'h09, 7'h11, 7'h05, 7'h39,
		7'h1D, 7'h21, 7'h1B, 7'h33, 7'h27};
	localparam logic [69:0] CODES_R = {7'h74, 7'h48, 7'h44, 7'h50, 7'h4E,
		7'h5C, 7'h42, 7'h6C, 7'h66, 7'h72};
	// Parity masks, first left character at bit 5, 1 selects the even code.
	localparam logic [59:0] PARITY_EAN13 = {6'h1A, 6'h16, 6'h15, 6'h1C, 6'h19,
		6'h13, 6'h0E, 6'h0D, 6'h0B, 6'h00};
	localparam logic [59:0] PARITY_UPCE0 = {6'h25, 6'h29, 6'h2A, 6'h23, 6'h26,
		6'h2C, 6'h31, 6'h32, 6'h34, 6'h38};
	localparam logic [2:0] SIDE_GUARD   = 3'b101;
	localparam logic [4:0] MIDDLE_GUARD = 5'b01010;
	localparam logic [5:0] UPCE_END     = 6'b010101;

	localparam int ITEMS_PER_PHASE = 475;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int LONG_HOLD       = 120;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;

	request_t pending_q [$];
	symbol_t  symbol_q [$];
	int       outstanding = 0;
	int       error_count = 0;
	int       cycle_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       item_taken = 1'b0;
	bit       long_hold_go = 1'b0;
	int       hold_left = 0;

	ean_upc_module_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// Appends the n low bits of a pattern to the module row, highest bit first.
	function automatic void put_modules(inout logic [0:94] row, inout int pos,
			input logic [6:0] pattern, input int n);
		for (int k = 0; k < n; k++) begin
			row[pos] = pattern[n - 1 - k];
			pos++;
		end
	endfunction

	// Works out the symbol that one request must produce.
	function automatic symbol_t encode_symbol(request_t rq);
		symbol_t      sym;
		logic [3:0]   nib [13];
		int           v [13];
		logic [0:94]  row;
		int           pos;
		int           sum;
		int           cd;
		bit           len_ok;
		bit           given;
		logic [5:0]   par;

		sym = '0;
		sym.status = ST_OK;
		row = '0;
		pos = 0;
		cd = 0;
		for (int i = 0; i < 13; i++) begin
			nib[i] = rq.digits[4 * i +: 4];
			v[i] = 0;
		end

		case (rq.mode)
			MODE_EAN13: len_ok = (rq.count == 12 || rq.count == 13);
			MODE_UPCA:  len_ok = (rq.count == 11 || rq.count == 12);
			MODE_EAN8:  len_ok = (rq.count == 7 || rq.count == 8);
			default:    len_ok = (rq.count == 8);
		endcase

		// Length is judged first, then the supplied characters.
		if (!len_ok) begin
			sym.status = ST_BAD_LEN;
		end else begin
			for (int i = 0; i < rq.count; i++)
				if (nib[i] > 9)
					sym.status = ST_BAD_DIGIT;
		end

		if (sym.status == ST_OK) begin
			case (rq.mode) inside
				MODE_EAN13, MODE_UPCA: begin
					// UPC-A is EAN-13 with an implied leading zero.
					if (rq.mode == MODE_EAN13) begin
						for (int i = 0; i < 13; i++)
							v[i] = int'(nib[i]);
						given = (rq.count == 13);
					end else begin
						for (int i = 0; i < 12; i++)
							v[i + 1] = int'(nib[i]);
						given = (rq.count == 12);
					end
					sum = 0;
					for (int i = 0; i < 12; i++)
						sum += v[i] * ((i % 2) ? 3 : 1);
					cd = (10 - sum % 10) % 10;
					if (given && v[12] != cd) begin
						sym.status = ST_MISMATCH;
					end else begin
						v[12] = cd;
						par = PARITY_EAN13[6 * v[0] +: 6];
						put_modules(row, pos, 7'(SIDE_GUARD), 3);
						for (int i = 0; i < 6; i++)
							put_modules(row, pos, par[5 - i] ? CODES_G[7 * v[i + 1] +: 7]
								: CODES_L[7 * v[i + 1] +: 7], 7);
						put_modules(row, pos, 7'(MIDDLE_GUARD), 5);
						for (int i = 0; i < 6; i++)
							put_modules(row, pos, CODES_R[7 * v[i + 7] +: 7], 7);
						put_modules(row, pos, 7'(SIDE_GUARD), 3);
						sym.mod_count = 7'd95;
					end
				end
				MODE_EAN8: begin
					for (int i = 0; i < 8; i++)
						v[i] = int'(nib[i]);
					sum = 0;
					for (int i = 0; i < 7; i++)
						sum += v[i] * ((i % 2) ? 1 : 3);
					cd = (10 - sum % 10) % 10;
					if (rq.count == 8 && v[7] != cd) begin
						sym.status = ST_MISMATCH;
					end else begin
						v[7] = cd;
						put_modules(row, pos, 7'(SIDE_GUARD), 3);
						for (int i = 0; i < 4; i++)
							put_modules(row, pos, CODES_L[7 * v[i] +: 7], 7);
						put_modules(row, pos, 7'(MIDDLE_GUARD), 5);
						for (int i = 0; i < 4; i++)
							put_modules(row, pos, CODES_R[7 * v[i + 4] +: 7], 7);
						put_modules(row, pos, 7'(SIDE_GUARD), 3);
						sym.mod_count = 7'd67;
					end
				end
				default: begin
					// UPC-E: the supplied check digit picks the parity pattern.
					for (int i = 0; i < 8; i++)
						v[i] = int'(nib[i]);
					cd = v[7];
					if (v[0] > 1) begin
						sym.status = ST_BAD_NS;
					end else begin
						par = PARITY_UPCE0[6 * v[7] +: 6];
						if (v[0] == 1)
							par = ~par;
						put_modules(row, pos, 7'(SIDE_GUARD), 3);
						for (int i = 0; i < 6; i++)
							put_modules(row, pos, par[5 - i] ? CODES_G[7 * v[i + 1] +: 7]
								: CODES_L[7 * v[i + 1] +: 7], 7);
						put_modules(row, pos, 7'(UPCE_END), 6);
						sym.mod_count = 7'd51;
					end
				end
			endcase
			sym.check = cd[3:0];
		end

		if (sym.status == ST_OK) begin
			sym.first = row[0:47];
			sym.rest = row[48:94];
		end
		return sym;
	endfunction

	// Queues a request given as a string, character 0 first; A to F give nibbles above 9.
	task automatic queue_request(input mode_t md, input int cnt, input string chars);
		request_t rq;
		byte      c;

		rq = '0;
		rq.mode = md;
		rq.count = cnt[3:0];
		for (int i = 0; i < chars.len(); i++) begin
			c = chars[i];
			rq.digits[4 * i +: 4] = (c >= "A") ? 4'(c - "A" + 10) : 4'(c - "0");
		end
		pending_q.push_back(rq);
	endtask

	// Compares one result field and reports a difference.
	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Request driver: holds an item until it is taken, idles at random between items.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || item_taken) begin
			item_taken = 1'b0;
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata <= {6'b0, pending_q.pop_front()};
				s_axis_tvalid <= 1'b1;
				outstanding++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_hold_go) begin
			long_hold_go = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts on every accepted request and checks every accepted result.
	always @(posedge clk) begin
		symbol_t want;
		symbol_t got;

		if (s_axis_tvalid && s_axis_tready) begin
			item_taken = 1'b1;
			symbol_q.push_back(encode_symbol(request_t'(s_axis_tdata[57:0])));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = symbol_t'(m_axis_tdata[108:0]);
			if (symbol_q.size() == 0) begin
				error_count++;
				$display("%0t: result with no request pending, got %0h", $time, got);
			end else begin
				want = symbol_q.pop_front();
				outstanding--;
				check_field("status", 64'(want.status), 64'(got.status));
				check_field("check_digit", 64'(want.check), 64'(got.check));
				check_field("module_count", 64'(want.mod_count), 64'(got.mod_count));
				check_field("modules_first", 64'(want.first), 64'(got.first));
				check_field("modules_rest", 64'(want.rest), 64'(got.rest));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: reset, directed requests, then random requests in four idling phases.
	initial begin
		request_t rq;
		request_t probe;
		symbol_t  sym;
		bit       long_form;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// EAN-13: plain, supplied check, mismatch, bad length, bad character.
		queue_request(MODE_EAN13, 12, "000000000000");
		queue_request(MODE_EAN13, 13, "5901234123457");
		queue_request(MODE_EAN13, 13, "5901234123458");
		queue_request(MODE_EAN13, 13, "9999999999994");
		queue_request(MODE_EAN13, 11, "59012341234");
		queue_request(MODE_EAN13, 15, "FFFFFFFFFFFFF");
		queue_request(MODE_EAN13, 12, "59012341A345");
		// UPC-A with and without the check digit, a mismatch and a bad length.
		queue_request(MODE_UPCA, 11, "03600029145");
		queue_request(MODE_UPCA, 12, "036000291452");
		queue_request(MODE_UPCA, 12, "036000291453");
		queue_request(MODE_UPCA, 13, "0360002914520");
		// EAN-8, including junk beyond the count that must be ignored.
		queue_request(MODE_EAN8, 7, "9638507");
		queue_request(MODE_EAN8, 8, "96385074");
		queue_request(MODE_EAN8, 8, "96385070");
		queue_request(MODE_EAN8, 7, "9638507FFFFFF");
		queue_request(MODE_EAN8, 6, "963850");
		// UPC-E: both number systems, a bad one, and the error order.
		queue_request(MODE_UPCE, 8, "04252614");
		queue_request(MODE_UPCE, 8, "19999999");
		queue_request(MODE_UPCE, 8, "20000000");
		queue_request(MODE_UPCE, 7, "0425261");
		queue_request(MODE_UPCE, 8, "0425261F");
		queue_request(MODE_UPCE, 8, "2A000000");
		queue_request(MODE_UPCE, 0, "");

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				rq.mode = mode_t'($urandom_range(3));
				rq.digits = 52'({$urandom, $urandom});
				if ($urandom_range(99) < 20) begin
					// Noise: any count, any characters.
					rq.count = 4'($urandom_range(15));
				end else begin
					case (rq.mode)
						MODE_EAN13: rq.count = 4'(12 + $urandom_range(1));
						MODE_UPCA:  rq.count = 4'(11 + $urandom_range(1));
						MODE_EAN8:  rq.count = 4'(7 + $urandom_range(1));
						default:    rq.count = 4'd8;
					endcase
					for (int i = 0; i < rq.count; i++)
						rq.digits[4 * i +: 4] = 4'($urandom_range(9));
					if (rq.mode == MODE_UPCE && $urandom_range(9) != 0)
						rq.digits[3:0] = 4'($urandom_range(1));
					// A supplied check digit is mostly the right one.
					long_form = (rq.mode == MODE_EAN13 && rq.count == 13)
						|| (rq.mode == MODE_UPCA && rq.count == 12)
						|| (rq.mode == MODE_EAN8 && rq.count == 8);
					if (long_form) begin
						probe = rq;
						probe.count = rq.count - 4'd1;
						sym = encode_symbol(probe);
						rq.digits[4 * (rq.count - 1) +: 4] =
							($urandom_range(9) == 0) ? 4'($urandom_range(9)) : sym.check;
					end
					if ($urandom_range(19) == 0)
						rq.digits[4 * $urandom_range(rq.count - 1) +: 4] =
							4'(10 + $urandom_range(5));
				end
				pending_q.push_back(rq);
			end

			// Hold the results back while requests keep coming, so the block backs up.
			if (phase == 0)
				long_hold_go = 1'b1;

			// Let every request out and every result back before the next phase.
			do
				@(posedge clk);
			while (pending_q.size() != 0 || outstanding != 0);
		end

		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
